// ----- src/i2c_register_access_master_top_defines.svh -----
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Shared concurrent assertion forms for the block, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// check outside reset
`define I2CRAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check an effect in the cycle after its cause, outside reset
`define I2CRAM_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

// ----- src/i2cram_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - package
// Payload types, request codes, bus operation codes and the sequence tables.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam int          TICK_WIDTH_DEFAULT = 16;
    localparam int          PHASE_TICKS_W      = 16;
    localparam logic [15:0] PHASE_TICKS_RESET  = 16'd10;

    localparam logic [1:0]  FUNC_NONE  = 2'd0;
    localparam logic [1:0]  FUNC_WRITE = 2'd1;
    localparam logic [1:0]  FUNC_READ  = 2'd2;

    localparam int          STEP_W          = 3;
    localparam logic [2:0]  STEP_IDLE       = 3'd0;
    localparam logic [2:0]  STEP_FIRST      = 3'd1;
    localparam logic [2:0]  STEP_LAST_WRITE = 3'd5;
    localparam logic [2:0]  STEP_LAST_READ  = 3'd7;

    localparam logic [1:0]  PH_LEAD = 2'd0;
    localparam logic [1:0]  PH_HIGH = 2'd1;
    localparam logic [1:0]  PH_LOW  = 2'd2;
    localparam logic [1:0]  PH_TAIL = 2'd3;

    localparam logic [2:0]  BIT_LAST = 3'd7;

    typedef enum logic [6:0] {
        OP_START = 7'b0000001,
        OP_TX_AW = 7'b0000010,
        OP_TX_REG = 7'b0000100,
        OP_TX_VAL = 7'b0001000,
        OP_TX_AR = 7'b0010000,
        OP_RX = 7'b0100000,
        OP_STOP = 7'b1000000
    } t_op;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic       sda_level;
        logic       scl_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_out_item;

    function automatic t_op op_of(input logic is_read, input logic [2:0] step);
        t_op op;
        op = OP_STOP;
        if (is_read) begin
            case (step)
                3'd1: op = OP_START;
                3'd2: op = OP_TX_AW;
                3'd3: op = OP_TX_REG;
                3'd4: op = OP_START;
                3'd5: op = OP_TX_AR;
                3'd6: op = OP_RX;
                default: op = OP_STOP;
            endcase
        end else begin
            case (step)
                3'd1: op = OP_START;
                3'd2: op = OP_TX_AW;
                3'd3: op = OP_TX_REG;
                3'd4: op = OP_TX_VAL;
                default: op = OP_STOP;
            endcase
        end
        return op;
    endfunction

endpackage

// ----- src/i2c_register_access_master_top.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Open-drain I2C master for single-register writes and reads.
//
// Channels: the input channel carries one request per time tick (request
// code, addresses, write value and the sampled SDA/SCL levels); the output
// channel returns one result per request (pin pull-downs, busy, done pulse,
// last read byte). The config channel writes phase_ticks, the ticks per bus
// phase; write it only while no transaction is running.
// A request waits in the input register, and its result is registered in the
// output register when the request advances.
// Throughput: one request per cycle while the output is taken, set by the
// single-pass tick engine between the input and output registers.
// Reset: synchronous, active low; bus released, sequence idle, read byte
// zero, phase_ticks back to 10.
// Receiver stall: the output register holds its result, the input register
// holds the next request and ready drops until the output is taken.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top #(
    parameter int TICK_WIDTH = i2cram_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  i2cram_pkg::t_in_item                 i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output i2cram_pkg::t_out_item                o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [i2cram_pkg::PHASE_TICKS_W-1:0] i_cfg_data
);
    import i2cram_pkg::*;

    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic [PHASE_TICKS_W-1:0] r_phase_ticks;
    logic                     w_advance;
    t_out_item                w_res;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_phase_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    i2cram_engine #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_item        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .o_res         (w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/i2cram_engine.sv -----
// ----------------------------------------------------------------------------
// I2C register access master - sequencing engine
// Holds the transaction state and advances it by one tick per step strobe.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_top_defines.svh"

module i2cram_engine #(
    parameter int TICK_WIDTH = i2cram_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_step,
    input  i2cram_pkg::t_in_item                     i_item,
    input  logic [i2cram_pkg::PHASE_TICKS_W-1:0]     i_phase_ticks,
    output i2cram_pkg::t_out_item                    o_res
);
    import i2cram_pkg::*;

    localparam int CW = (TICK_WIDTH >= PHASE_TICKS_W) ? TICK_WIDTH + 1 : PHASE_TICKS_W + 1;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_pins;

    logic [STEP_W-1:0]     r_step, n_step;
    logic [1:0]            r_phase, n_phase;
    logic [2:0]            r_bit, n_bit;
    logic [7:0]            r_shift, n_shift;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic                  r_is_read, n_is_read;
    logic [6:0]            r_device, n_device;
    logic [7:0]            r_register, n_register;
    logic [7:0]            r_value, n_value;
    logic [7:0]            r_recv, n_recv;
    t_pins                 r_pins, n_pins;

    t_op                   w_op;
    t_op                   w_new_op;
    logic [CW-1:0]         w_limit;
    logic [CW-1:0]         w_eff;
    logic [CW-1:0]         w_tc1;
    logic                  w_wait;
    logic                  w_done;
    logic                  w_begin;
    logic [STEP_W-1:0]     w_last_step;

    function automatic t_pins enter_pins(input t_op op, input logic [1:0] phase,
                                         input logic msb, input t_pins pins);
        t_pins p;
        p = pins;
        case (op)
            OP_START: begin
                case (phase)
                    PH_LEAD: p.sda = 1'b0;
                    PH_HIGH: p.scl = 1'b0;
                    PH_LOW:  p.sda = 1'b1;
                    default: p.scl = 1'b1;
                endcase
            end
            OP_STOP: begin
                case (phase)
                    PH_LEAD: p.sda = 1'b1;
                    PH_HIGH: p.scl = 1'b0;
                    default: p.sda = 1'b0;
                endcase
            end
            OP_RX: begin
                case (phase)
                    PH_LEAD: p.sda = 1'b0;
                    PH_HIGH: p.scl = 1'b0;
                    PH_LOW:  p.scl = 1'b1;
                    default: p = '0;
                endcase
            end
            OP_TX_AW, OP_TX_REG, OP_TX_VAL, OP_TX_AR: begin
                case (phase)
                    PH_HIGH: begin
                        p.sda = ~msb;
                        p.scl = 1'b0;
                    end
                    PH_LOW:  p.scl = 1'b1;
                    PH_TAIL: p = '0;
                    default: p = pins;
                endcase
            end
            default: p = pins;
        endcase
        return p;
    endfunction

    assign w_op    = op_of(r_is_read, r_step);
    assign w_limit = CW'(1) << TICK_WIDTH;
    assign w_tc1   = CW'(r_tick) + CW'(1);

    always_comb begin
        if (i_phase_ticks == '0) begin
            w_eff = CW'(1);
        end else if (CW'(i_phase_ticks) > w_limit) begin
            w_eff = w_limit;
        end else begin
            w_eff = CW'(i_phase_ticks);
        end
    end

    assign w_wait = (w_op == OP_RX) && (r_phase == PH_HIGH) && (r_tick == '0)
                    && !i_item.scl_level;

    always_comb begin
        n_step     = r_step;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_tick     = r_tick;
        n_is_read  = r_is_read;
        n_device   = r_device;
        n_register = r_register;
        n_value    = r_value;
        n_recv     = r_recv;
        n_pins     = r_pins;
        w_done     = 1'b0;
        w_begin    = 1'b0;
        w_new_op   = OP_STOP;

        if (r_step == STEP_IDLE) begin
            if (i_item.func == FUNC_WRITE || i_item.func == FUNC_READ) begin
                n_is_read  = (i_item.func == FUNC_READ);
                n_device   = i_item.device_address;
                n_register = i_item.register_address;
                n_value    = i_item.write_value;
                n_tick     = '0;
                n_step     = STEP_FIRST;
                w_begin    = 1'b1;
            end
        end else if (!w_wait) begin
            if (w_tc1 >= w_eff) begin
                n_tick = '0;
                case (w_op)
                    OP_START: begin
                        if (r_phase != PH_TAIL) begin
                            n_phase = r_phase + 2'd1;
                            n_pins  = enter_pins(w_op, n_phase, r_shift[7], r_pins);
                        end else begin
                            w_begin = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (r_phase == PH_LEAD || r_phase == PH_HIGH) begin
                            n_phase = r_phase + 2'd1;
                            n_pins  = enter_pins(w_op, n_phase, r_shift[7], r_pins);
                        end else begin
                            n_step  = STEP_IDLE;
                            n_phase = PH_LEAD;
                            w_done  = 1'b1;
                        end
                    end
                    OP_RX: begin
                        case (r_phase)
                            PH_LEAD: begin
                                n_shift = '0;
                                n_bit   = '0;
                                n_phase = PH_HIGH;
                            end
                            PH_HIGH: begin
                                n_shift = {r_shift[6:0], i_item.sda_level};
                                n_phase = PH_LOW;
                            end
                            PH_LOW: begin
                                if (r_bit == BIT_LAST) begin
                                    n_recv  = r_shift;
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_bit   = r_bit + 3'd1;
                                    n_phase = PH_HIGH;
                                end
                            end
                            default: begin
                                n_pins.scl = 1'b1;
                                n_pins.sda = 1'b0;
                                w_begin    = 1'b1;
                            end
                        endcase
                        if (!w_begin) begin
                            n_pins = enter_pins(w_op, n_phase, n_shift[7], r_pins);
                        end
                    end
                    OP_TX_AW, OP_TX_REG, OP_TX_VAL, OP_TX_AR: begin
                        case (r_phase)
                            PH_LEAD: begin
                                n_bit   = '0;
                                n_phase = PH_HIGH;
                            end
                            PH_HIGH: n_phase = PH_LOW;
                            PH_LOW: begin
                                if (r_bit == BIT_LAST) begin
                                    n_phase = PH_TAIL;
                                end else begin
                                    n_bit   = r_bit + 3'd1;
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_phase = PH_HIGH;
                                end
                            end
                            default: begin
                                n_pins.scl = 1'b1;
                                w_begin    = 1'b1;
                            end
                        endcase
                        if (!w_begin) begin
                            n_pins = enter_pins(w_op, n_phase, n_shift[7], r_pins);
                        end
                    end
                    default: n_tick = '0;
                endcase
                if (w_begin) begin
                    n_step = r_step + STEP_W'(1);
                end
            end else begin
                n_tick = r_tick + TICK_WIDTH'(1);
            end
        end

        if (w_begin) begin
            w_new_op = op_of(n_is_read, n_step);
            n_phase  = PH_LEAD;
            n_bit    = '0;
            case (w_new_op)
                OP_TX_AW:  n_shift = {n_device, 1'b0};
                OP_TX_AR:  n_shift = {n_device, 1'b1};
                OP_TX_REG: n_shift = n_register;
                OP_TX_VAL: n_shift = n_value;
                default:   n_shift = n_shift;
            endcase
            n_pins = enter_pins(w_new_op, PH_LEAD, n_shift[7], n_pins);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= STEP_IDLE;
            r_phase    <= PH_LEAD;
            r_bit      <= '0;
            r_shift    <= '0;
            r_tick     <= '0;
            r_is_read  <= 1'b0;
            r_device   <= '0;
            r_register <= '0;
            r_value    <= '0;
            r_recv     <= '0;
            r_pins     <= '0;
        end else if (i_step) begin
            r_step     <= n_step;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_tick     <= n_tick;
            r_is_read  <= n_is_read;
            r_device   <= n_device;
            r_register <= n_register;
            r_value    <= n_value;
            r_recv     <= n_recv;
            r_pins     <= n_pins;
        end
    end

    assign o_res.scl_pull_low = r_pins.scl;
    assign o_res.sda_pull_low = r_pins.sda;
    assign o_res.busy_res     = (r_step != STEP_IDLE);
    assign o_res.done_res     = w_done;
    assign o_res.read_data    = r_recv;

    assign w_last_step = r_is_read ? STEP_LAST_READ : STEP_LAST_WRITE;

    `I2CRAM_ASSERT_NEXT(a_done_idles, i_step && w_done, r_step == STEP_IDLE, "done not idle")
    `I2CRAM_ASSERT(a_idle_releases_bus, (r_step == STEP_IDLE) |-> (r_pins == '0), "bus held idle")
    `I2CRAM_ASSERT(a_step_in_sequence, r_step <= w_last_step, "step beyond sequence end")
    `I2CRAM_ASSERT_NEXT(a_stretch_holds, i_step && w_wait, $stable({r_phase, r_tick}), "stretch lost")

endmodule

// ----- dv/i2c_register_access_master_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master - testbench
// Drives one bus tick per request and predicts the pin pull-downs, busy, done
// and read byte of each tick. Covers idle and unused request codes, writes
// and reads at phase_ticks 0-7, a read at 65535, clock stretching, requests
// while busy, and random bus traffic under random stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top_tb;
    import i2cram_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_item                 in_item   = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [PHASE_TICKS_W-1:0] cfg_data  = '0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    t_out_item                o_out_item;
    logic                     o_cfg_ready;

    i2c_register_access_master_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL i2c_register_access_master_top");
        $finish;
    end

    // bus state as the master sees it
    logic [15:0] m_phase_ticks = PHASE_TICKS_RESET;
    logic [5:0]  m_step        = '0;
    logic [3:0]  m_bits        = '0;
    logic [7:0]  m_shift       = '0;
    logic [16:0] m_ticks       = '0;
    logic        m_is_read     = 1'b0;
    logic [6:0]  m_dev         = '0;
    logic [7:0]  m_reg         = '0;
    logic [7:0]  m_val         = '0;
    logic [7:0]  m_rx          = '0;
    logic [1:0]  m_phase       = PH_LEAD;
    logic        m_scl_low     = 1'b0;
    logic        m_sda_low     = 1'b0;

    t_out_item pin_state_q[$];

    int gap_max     = 0;
    int stall_max   = 0;
    int n_ticks     = 0;
    int n_transfers = 0;
    int n_reads     = 0;
    int n_stretch   = 0;
    int n_cfg       = 0;
    int n_fail      = 0;

    function automatic t_op bus_op();
        t_op op;
        op = OP_STOP;
        case (m_step)
            6'd1: op = OP_START;
            6'd2: op = OP_TX_AW;
            6'd3: op = OP_TX_REG;
            6'd4: begin
                if (m_is_read) op = OP_START;
                else op = OP_TX_VAL;
            end
            6'd5: begin
                if (m_is_read) op = OP_TX_AR;
            end
            6'd6: begin
                if (m_is_read) op = OP_RX;
            end
            default: op = OP_STOP;
        endcase
        return op;
    endfunction

    task automatic drive_pins();
        case (bus_op())
            OP_START: begin
                case (m_phase)
                    PH_LEAD: m_sda_low = 1'b0;
                    PH_HIGH: m_scl_low = 1'b0;
                    PH_LOW:  m_sda_low = 1'b1;
                    default: m_scl_low = 1'b1;
                endcase
            end
            OP_STOP: begin
                case (m_phase)
                    PH_LEAD: m_sda_low = 1'b1;
                    PH_HIGH: m_scl_low = 1'b0;
                    default: m_sda_low = 1'b0;
                endcase
            end
            OP_RX: begin
                case (m_phase)
                    PH_LEAD: m_sda_low = 1'b0;
                    PH_HIGH: m_scl_low = 1'b0;
                    PH_LOW:  m_scl_low = 1'b1;
                    default: begin
                        m_sda_low = 1'b0;
                        m_scl_low = 1'b0;
                    end
                endcase
            end
            default: begin
                case (m_phase)
                    PH_HIGH: begin
                        m_sda_low = ~m_shift[7];
                        m_scl_low = 1'b0;
                    end
                    PH_LOW: m_scl_low = 1'b1;
                    PH_TAIL: begin
                        m_sda_low = 1'b0;
                        m_scl_low = 1'b0;
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    task automatic load_op();
        m_phase = PH_LEAD;
        m_bits  = '0;
        case (bus_op())
            OP_TX_AW:  m_shift = {m_dev, 1'b0};
            OP_TX_AR:  m_shift = {m_dev, 1'b1};
            OP_TX_REG: m_shift = m_reg;
            OP_TX_VAL: m_shift = m_val;
            default: ;
        endcase
        drive_pins();
    endtask

    task automatic end_of_phase(input logic sda_in, output logic fin);
        logic next_op;
        fin     = 1'b0;
        next_op = 1'b0;
        case (bus_op())
            OP_START: begin
                if (m_phase != PH_TAIL) begin
                    m_phase++;
                    drive_pins();
                end else begin
                    next_op = 1'b1;
                end
            end
            OP_STOP: begin
                if (m_phase == PH_LEAD || m_phase == PH_HIGH) begin
                    m_phase++;
                    drive_pins();
                end else begin
                    m_step  = '0;
                    m_phase = PH_LEAD;
                    fin     = 1'b1;
                end
            end
            OP_RX: begin
                case (m_phase)
                    PH_LEAD: begin
                        m_shift = '0;
                        m_bits  = '0;
                        m_phase = PH_HIGH;
                        drive_pins();
                    end
                    PH_HIGH: begin
                        m_shift = {m_shift[6:0], sda_in};
                        m_phase = PH_LOW;
                        drive_pins();
                    end
                    PH_LOW: begin
                        if (m_bits >= BIT_LAST) begin
                            m_rx    = m_shift;
                            m_phase = PH_TAIL;
                        end else begin
                            m_bits++;
                            m_phase = PH_HIGH;
                        end
                        drive_pins();
                    end
                    default: begin
                        m_scl_low = 1'b1;
                        m_sda_low = 1'b0;
                        next_op   = 1'b1;
                    end
                endcase
            end
            default: begin
                case (m_phase)
                    PH_LEAD: begin
                        m_bits  = '0;
                        m_phase = PH_HIGH;
                        drive_pins();
                    end
                    PH_HIGH: begin
                        m_phase = PH_LOW;
                        drive_pins();
                    end
                    PH_LOW: begin
                        if (m_bits >= BIT_LAST) begin
                            m_phase = PH_TAIL;
                        end else begin
                            m_bits++;
                            m_shift = m_shift << 1;
                            m_phase = PH_HIGH;
                        end
                        drive_pins();
                    end
                    default: begin
                        m_scl_low = 1'b1;
                        next_op   = 1'b1;
                    end
                endcase
            end
        endcase
        if (next_op) begin
            m_step = m_step + 6'd1;
            load_op();
        end
    endtask

    task automatic predict_bus_tick(input t_in_item it);
        t_out_item   res;
        logic [16:0] span;
        logic        fin;
        res.scl_pull_low = m_scl_low;
        res.sda_pull_low = m_sda_low;
        res.busy_res     = (m_step != 0);
        res.read_data    = m_rx;
        fin  = 1'b0;
        span = (m_phase_ticks == 0) ? 17'd1 : {1'b0, m_phase_ticks};
        if (m_step == 0) begin
            if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
                m_is_read = (it.func == FUNC_READ);
                m_dev     = it.device_address;
                m_reg     = it.register_address;
                m_val     = it.write_value;
                m_ticks   = '0;
                m_step    = 6'd1;
                load_op();
            end
        end else if (bus_op() == OP_RX && m_phase == PH_HIGH && m_ticks == 0 && !it.scl_level) begin
            n_stretch++;
        end else if (m_ticks + 17'd1 >= span) begin
            m_ticks = '0;
            end_of_phase(it.sda_level, fin);
        end else begin
            m_ticks++;
        end
        res.done_res = fin;
        pin_state_q.push_back(res);
        n_ticks++;
    endtask

    task automatic send_tick(input t_in_item it);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
        predict_bus_tick(it);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pin_state_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_phase_ticks(input logic [15:0] value);
        hold_until_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid     <= 1'b0;
        m_phase_ticks = value;
        n_cfg++;
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        it.func             = 2'($urandom);
        it.device_address   = 7'($urandom);
        it.register_address = 8'($urandom);
        it.write_value      = 8'($urandom);
        it.sda_level        = 1'($urandom);
        it.scl_level        = 1'($urandom);
        return it;
    endfunction

    task automatic idle_ticks(input int count, input bit noisy);
        t_in_item it;
        repeat (count) begin
            it      = random_item();
            it.func = (noisy && $urandom_range(0, 1) == 1) ? FUNC_UNUSED : FUNC_NONE;
            send_tick(it);
        end
    endtask

    task automatic run_transfer(input logic [1:0] kind, input logic [6:0] dev,
                                input logic [7:0] reg_index, input logic [7:0] wr_val,
                                input logic [7:0] slave_byte, input bit stretch,
                                input bit noise, input int pause_after);
        t_in_item it;
        int       n;
        it                  = random_item();
        it.func             = kind;
        it.device_address   = dev;
        it.register_address = reg_index;
        it.write_value      = wr_val;
        send_tick(it);
        n_transfers++;
        if (kind == FUNC_READ) n_reads++;
        n = 0;
        while (m_step != 0) begin
            it = random_item();
            if (!noise) it.func = FUNC_NONE;
            if (bus_op() == OP_RX && m_phase == PH_HIGH) begin
                it.sda_level = slave_byte[3'd7 - m_bits[2:0]];
                if (m_ticks == 0) it.scl_level = stretch ? ($urandom_range(0, 2) == 0) : 1'b1;
            end
            send_tick(it);
            n++;
            if (n == pause_after) hold_until_drained();
        end
    endtask

    function automatic int pick_idle();
        return ($urandom_range(0, 2) == 0) ? 0 : 18;
    endfunction

    task automatic test_idle_after_reset();
        gap_max   = 0;
        stall_max = 0;
        idle_ticks(8, 1'b1);
    endtask

    task automatic test_reset_phase_ticks();
        run_transfer(FUNC_WRITE, 7'h55, 8'hAA, 8'h5A, 8'h00, 1'b0, 1'b0, 0);
        idle_ticks(3, 1'b1);
    endtask

    task automatic test_directed_transfers();
        gap_max   = 18;
        stall_max = 18;
        write_phase_ticks(16'd0);
        run_transfer(FUNC_WRITE, 7'h7F, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 0);
        run_transfer(FUNC_WRITE, 7'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 0);
        run_transfer(FUNC_READ,  7'h7F, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 0);
        run_transfer(FUNC_READ,  7'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b1, 40);
        write_phase_ticks(16'd1);
        idle_ticks(4, 1'b1);
        run_transfer(FUNC_READ,  7'h2A, 8'h5A, 8'hA5, 8'hA5, 1'b1, 1'b1, 0);
        write_phase_ticks(16'd2);
        gap_max   = 0;
        stall_max = 0;
        run_transfer(FUNC_READ,  7'h55, 8'hA5, 8'h5A, 8'h5A, 1'b1, 1'b0, 0);
    endtask

    task automatic test_random_traffic();
        int          target;
        logic [15:0] setting;
        target = 1730;
        while (n_ticks < target) begin
            case ($urandom_range(0, 7))
                0:       setting = 16'd0;
                1, 2, 3: setting = 16'd1;
                4, 5:    setting = 16'd2;
                6:       setting = 16'd3;
                default: setting = 16'($urandom_range(4, 7));
            endcase
            write_phase_ticks(setting);
            gap_max   = pick_idle();
            stall_max = pick_idle();
            repeat ($urandom_range(2, 4)) begin
                if (n_ticks < target) begin
                    idle_ticks($urandom_range(0, 3), 1'($urandom));
                    run_transfer($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
                                 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 1'($urandom), ($urandom_range(0, 3) != 0),
                                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80) : 0);
                end
            end
        end
    endtask

    task automatic test_slowest_phase();
        t_in_item it;
        gap_max   = 18;
        stall_max = 18;
        write_phase_ticks(16'hFFFF);
        it      = random_item();
        it.func = FUNC_READ;
        send_tick(it);
        n_transfers++;
        n_reads++;
        repeat (120) send_tick(random_item());
    endtask

    initial begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_out_valid);
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pin_state_q.size() == 0) begin
                $error("result with no request outstanding");
                n_fail++;
            end else begin
                want = pin_state_q.pop_front();
                if (o_out_item.scl_pull_low !== want.scl_pull_low) begin
                    $error("scl_pull_low: expected %0d, got %0d",
                           want.scl_pull_low, o_out_item.scl_pull_low);
                    n_fail++;
                end
                if (o_out_item.sda_pull_low !== want.sda_pull_low) begin
                    $error("sda_pull_low: expected %0d, got %0d",
                           want.sda_pull_low, o_out_item.sda_pull_low);
                    n_fail++;
                end
                if (o_out_item.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d",
                           want.busy_res, o_out_item.busy_res);
                    n_fail++;
                end
                if (o_out_item.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d",
                           want.done_res, o_out_item.done_res);
                    n_fail++;
                end
                if (o_out_item.read_data !== want.read_data) begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           want.read_data, o_out_item.read_data);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_reset_phase_ticks();
        test_directed_transfers();
        test_random_traffic();
        test_slowest_phase();
        hold_until_drained();
        repeat (10) @(posedge clk);
        if (pin_state_q.size() != 0) begin
            $error("%0d results never arrived", pin_state_q.size());
            n_fail++;
        end
        $display("Ran %0d bus ticks over %0d transfers (%0d reads), %0d ticks held by stretching",
                 n_ticks, n_transfers, n_reads, n_stretch);
        $display("Changed phase_ticks %0d times, from 0 and 1 up to 65535", n_cfg);
        if (n_fail == 0) begin
            $display("PASS i2c_register_access_master_top");
        end else begin
            $display("FAIL i2c_register_access_master_top");
        end
        $finish;
    end

endmodule
